[hdl/msb_pkg.sv]
`default_nettype none
package msb_pkg;

  localparam int SLOTS  = 16;
  localparam int STACKS = 4;

  // slot pointers carry one extra code: SLOTS itself is the null link
  localparam int PTR_W  = $clog2(SLOTS + 1);
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int SID_W  = 2;
  localparam int DATA_W = 32;

  localparam logic [PTR_W-1:0] PTR_NULL = PTR_W'(SLOTS);

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_BADID = 2'd3
  } status_t;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef struct packed {
    op_t                      operation;
    logic [SID_W-1:0]         stack_id;
    logic signed [DATA_W-1:0] push_value;
  } req_t;

  typedef struct packed {
    status_t                  status;
    logic signed [DATA_W-1:0] pop_value;
    logic                     store_full;
    logic                     stack_empty;
  } rsp_t;

  function automatic logic is_slot(input logic [PTR_W-1:0] p);
    return p < PTR_W'(SLOTS);
  endfunction

endpackage
`default_nettype wire

[hdl/multi_stack_shared_buffer.sv]
// Channel | Direction | Signals                      | Beat
// req     | in        | req_valid, req_stall, req    | operation, stack_id, push_value
// rsp     | out       | rsp_valid, rsp_stall, rsp    | status, pop_value, store_full, stack_empty
//
// A request is accepted in S_IDLE, which reads the link and data entries into registers;
// S_EXEC then writes them back and registers the response.
// Reset is synchronous with no clearing pass: slots never allocated are tracked by
// a high-water count and read their link as the next slot.
// A stalled response holds the block in its execute cycle; one response may wait
// while a new request is accepted.
`default_nettype none
module multi_stack_shared_buffer (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire msb_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output msb_pkg::rsp_t      rsp
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state, state_next;

  logic [msb_pkg::PTR_W-1:0]  link_mem [msb_pkg::SLOTS];
  logic [msb_pkg::DATA_W-1:0] data_mem [msb_pkg::SLOTS];
  logic [msb_pkg::PTR_W-1:0]  link_rd;
  logic [msb_pkg::DATA_W-1:0] data_rd;

  logic [msb_pkg::PTR_W-1:0] stack_head [msb_pkg::STACKS];
  logic [msb_pkg::PTR_W-1:0] free_head;
  logic [msb_pkg::PTR_W-1:0] hwm;

  msb_pkg::req_t             cur;
  logic [msb_pkg::PTR_W-1:0] cur_ptr;

  logic                      accept;
  logic                      fire;
  logic                      rd_badid;
  logic [msb_pkg::PTR_W-1:0] rd_ptr;
  logic                      badid;
  logic [msb_pkg::PTR_W-1:0] head_cur;
  logic [msb_pkg::PTR_W-1:0] nx;
  logic [msb_pkg::PTR_W-1:0] nx_n;
  logic                      push_ok;
  logic                      pop_ok;
  msb_pkg::rsp_t             rsp_next;

  assign accept    = req_valid && !req_stall;
  assign req_stall = (state != S_IDLE);
  assign fire      = (state == S_EXEC) && (!rsp_valid || !rsp_stall);

  assign rd_badid = 32'(req.stack_id) >= msb_pkg::STACKS;
  always_comb begin
    rd_ptr = free_head;
    if (req.operation == msb_pkg::OP_POP) begin
      rd_ptr = rd_badid ? msb_pkg::PTR_NULL : stack_head[req.stack_id];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      link_rd <= link_mem[rd_ptr[msb_pkg::SLOT_W-1:0]];
      data_rd <= data_mem[rd_ptr[msb_pkg::SLOT_W-1:0]];
      cur     <= req;
      cur_ptr <= rd_ptr;
    end
    if (fire && push_ok) begin
      link_mem[cur_ptr[msb_pkg::SLOT_W-1:0]] <= head_cur;
      data_mem[cur_ptr[msb_pkg::SLOT_W-1:0]] <= cur.push_value;
    end else if (fire && pop_ok) begin
      link_mem[cur_ptr[msb_pkg::SLOT_W-1:0]] <= free_head;
    end
  end

  assign badid    = 32'(cur.stack_id) >= msb_pkg::STACKS;
  assign head_cur = badid ? msb_pkg::PTR_NULL : stack_head[cur.stack_id];

  // slots at or above the high-water mark were never written; their next link is taken as the following slot
  assign nx   = (cur_ptr >= hwm) ? cur_ptr + 1'b1 : link_rd;
  assign nx_n = msb_pkg::is_slot(nx) ? nx : msb_pkg::PTR_NULL;

  assign push_ok = !badid && cur.operation == msb_pkg::OP_PUSH && msb_pkg::is_slot(cur_ptr);
  assign pop_ok  = !badid && cur.operation == msb_pkg::OP_POP  && msb_pkg::is_slot(cur_ptr);

  always_comb begin
    rsp_next.status      = msb_pkg::ST_OK;
    rsp_next.pop_value   = '0;
    rsp_next.store_full  = !msb_pkg::is_slot(free_head);
    rsp_next.stack_empty = !msb_pkg::is_slot(head_cur);
    if (badid) begin
      rsp_next.status      = msb_pkg::ST_BADID;
      rsp_next.stack_empty = 1'b1;
    end else if (push_ok) begin
      rsp_next.store_full  = !msb_pkg::is_slot(nx_n);
      rsp_next.stack_empty = 1'b0;
    end else if (pop_ok) begin
      rsp_next.pop_value   = data_rd;
      rsp_next.store_full  = 1'b0;
      rsp_next.stack_empty = !msb_pkg::is_slot(nx_n);
    end else if (cur.operation == msb_pkg::OP_PUSH) begin
      rsp_next.status = msb_pkg::ST_FULL;
    end else begin
      rsp_next.status = msb_pkg::ST_EMPTY;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = S_EXEC;
      S_EXEC:  if (fire) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      free_head <= '0;
      hwm       <= '0;
      for (int i = 0; i < msb_pkg::STACKS; i++) begin
        stack_head[i[msb_pkg::SID_W-1:0]] <= msb_pkg::PTR_NULL;
      end
    end else begin
      state <= state_next;
      if (fire) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (fire && push_ok) begin
        free_head                <= nx_n;
        stack_head[cur.stack_id] <= cur_ptr;
        if (cur_ptr == hwm) begin
          hwm <= hwm + 1'b1;
        end
      end else if (fire && pop_ok) begin
        free_head                <= cur_ptr;
        stack_head[cur.stack_id] <= nx_n;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp <= rsp_next;
    end
  end

endmodule
`default_nettype wire

[hdl/msb_checker.sv]
`default_nettype none
module msb_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          req_valid,
  input wire logic          req_stall,
  input wire msb_pkg::req_t req,
  input wire logic          rsp_valid,
  input wire logic          rsp_stall,
  input wire msb_pkg::rsp_t rsp
);

  a_rst_quiet: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("rsp_valid after reset");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled rsp beat changed");

  // a request beat keeps the block busy for its execute cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request accepted back to back");

  a_full_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == msb_pkg::ST_FULL |-> rsp.store_full)
    else $error("full status without store_full");

  a_pop_value: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.pop_value != '0 |-> rsp.status == msb_pkg::ST_OK)
    else $error("pop value on refused beat");

endmodule

bind multi_stack_shared_buffer msb_checker u_msb_checker (.*);
`default_nettype wire
